// ===== hw/rtl/hec_pkg.sv =====
package hec_pkg;

  // field and state widths
  localparam int COUNT_W    = 33;
  localparam int FRAC_W     = 24;
  localparam int EXP_W      = 6;
  localparam int LOG_W      = EXP_W + FRAC_W;
  localparam int MANT_W     = 31;
  localparam int LOG_SUM_W  = 62;
  localparam int TOTAL_W    = 34;
  localparam int OUT_W      = 32;
  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;
  localparam int BSIZE_W    = 5;

  // defaults
  localparam int MAX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 5'd8;

  // q1.31 one
  localparam logic [OUT_W-1:0] ONE_Q31 = 32'h8000_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'd1;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_NORM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BOUND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROP  = 2'd2;

  // queue word between front and back
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               zero;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [BSIZE_W-1:0] bit_size;
    logic [MODE_W-1:0]  mode;
  } cfg_t;

endpackage

// ===== hw/rtl/hec_hist_if.sv =====
interface hec_hist_if;
  import hec_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic               last;
  modport source (output valid, count, last, input ready);
  modport sink (input valid, count, last, output ready);
endinterface

// ===== hw/rtl/hec_result_if.sv =====
interface hec_result_if;
  import hec_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] entropy;
  logic [OUT_W-1:0] coefficient;
  logic             count_error;
  modport source (output valid, entropy, coefficient, count_error, input ready);
  modport sink (input valid, entropy, coefficient, count_error, output ready);
endinterface

// ===== hw/rtl/hec_front.sv =====
module hec_front (
  input  logic          clk,
  input  logic          rst,
  hec_hist_if.sink      hist,
  output logic          q_valid,
  output hec_pkg::item_t q_item,
  input  logic          q_pop
);
  import hec_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  logic               pop;
  item_t              word;

  assign hist.ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push       = hist.valid && hist.ready;
  assign pop        = q_pop && q_valid;
  assign q_valid    = (fill != '0);
  assign q_item     = mem[rd_ptr];

  // classify the incoming word
  always_comb begin
    word.count = hist.count;
    word.last  = hist.last;
    word.zero  = (hist.count == '0);
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hec_log2.sv =====
module hec_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hec_pkg::COUNT_W-1:0] arg,
  output logic                       done,
  output logic [hec_pkg::LOG_W-1:0]   res
);
  import hec_pkg::*;

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQR  = 2'd2;

  logic [1:0]            st;
  logic [COUNT_W-1:0]    x;
  logic [EXP_W-1:0]      e;
  logic [MANT_W-1:0]     m;
  logic [FRAC_W-1:0]     frac;
  logic [4:0]            step;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sqs;

  // square the mantissa, back to q1.30
  assign sq  = m * m;
  assign sqs = sq[2*MANT_W-1:MANT_W-1];
  assign res = {e, frac};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        L_IDLE: begin
          if (start) begin
            st <= L_NORM;
          end
        end
        L_NORM: begin
          if (x[COUNT_W-1]) begin
            st <= L_SQR;
          end
        end
        L_SQR: begin
          if (step == 5'(FRAC_W - 1)) begin
            st   <= L_IDLE;
            done <= 1'b1;
          end
        end
        default: begin
          st <= L_IDLE;
        end
      endcase
    end
  end

  // datapath: shift to leading one, then one fraction bit per squaring
  always_ff @(posedge clk) begin
    case (st)
      L_IDLE: begin
        x <= arg;
        e <= EXP_W'(COUNT_W - 1);
      end
      L_NORM: begin
        if (x[COUNT_W-1]) begin
          m    <= x[COUNT_W-1:COUNT_W-MANT_W];
          step <= '0;
          frac <= '0;
        end else begin
          x <= {x[COUNT_W-2:0], 1'b0};
          e <= e - 1'b1;
        end
      end
      L_SQR: begin
        m    <= sqs[MANT_W] ? sqs[MANT_W:1] : sqs[MANT_W-1:0];
        frac <= {frac[FRAC_W-2:0], sqs[MANT_W]};
        step <= step + 1'b1;
      end
      default: begin
        x <= x;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hec_div.sv =====
module hec_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hec_pkg::DIV_NUM_W-1:0] num,
  input  logic [hec_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [hec_pkg::DIV_NUM_W-1:0] quo
);
  import hec_pkg::*;

  localparam int STEP_W = $clog2(DIV_NUM_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIV_NUM_W-1:0]  n;
  logic [DIV_DEN_W-1:0]  d;
  logic [DIV_DEN_W-1:0]  rem;
  logic [DIV_DEN_W:0]    r2;
  logic [DIV_DEN_W:0]    diff;
  logic                  ge;

  // one restoring step
  assign r2   = {rem, n[DIV_NUM_W-1]};
  assign diff = r2 - {1'b0, d};
  assign ge   = (r2 >= {1'b0, d});
  assign quo  = n;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // quotient shifts into the numerator register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      n    <= num;
      d    <= den;
      rem  <= '0;
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
      n    <= {n[DIV_NUM_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/hec_back.sv =====
module hec_back #(
  parameter int MAX_BITS = hec_pkg::MAX_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  hec_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  hec_pkg::item_t q_item,
  output logic           q_pop,
  hec_result_if.source   result
);
  import hec_pkg::*;

  localparam int BW     = $clog2(MAX_BITS + 1);
  localparam int TBW    = BW + 1;
  localparam int HALF_W = LOG_W / 2;
  localparam int PP_W   = COUNT_W + HALF_W;
  localparam int PROD_W = COUNT_W + LOG_W;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_LOG  = 4'd1;
  localparam logic [3:0] B_MUL0 = 4'd2;
  localparam logic [3:0] B_MUL1 = 4'd3;
  localparam logic [3:0] B_SUM  = 4'd4;
  localparam logic [3:0] B_ACC  = 4'd5;
  localparam logic [3:0] B_FIN  = 4'd6;
  localparam logic [3:0] B_BLOG = 4'd7;
  localparam logic [3:0] B_DIV  = 4'd8;
  localparam logic [3:0] B_OUT  = 4'd9;

  logic [3:0]            st;
  logic [COUNT_W-1:0]    cnt;
  logic                  is_last;
  logic [LOG_W-1:0]      lg;
  logic [PP_W-1:0]       p_lo;
  logic [PP_W-1:0]       p_hi;
  logic [PROD_W-1:0]     prod;
  logic [LOG_SUM_W-1:0]  log_sum;
  logic [TOTAL_W-1:0]    total_count;
  logic [COUNT_W-1:0]    first_bin_count;
  logic                  first_item;
  logic [OUT_W-1:0]      h;
  logic [OUT_W-1:0]      coef;
  logic                  err;
  logic                  out_valid;
  logic                  out_load;

  logic                  log_start;
  logic [COUNT_W-1:0]    log_arg;
  logic                  log_done;
  logic [LOG_W-1:0]      log_res;
  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quo;

  logic [BW-1:0]         b;
  logic [TBW-1:0]        tb;
  logic [TOTAL_W:0]      tsum;
  logic [63:0]           asum;
  logic [LOG_SUM_W-1:0]  term;
  logic [LOG_SUM_W-1:0]  two_b_q;
  logic [LOG_SUM_W-1:0]  h_wide;
  logic [OUT_W-1:0]      h_next;
  logic [COUNT_W-1:0]    bound_arg;
  logic [63:0]           prop_wide;
  logic [OUT_W-1:0]      prop_coef;
  logic [63:0]           one_tb;
  logic                  err_next;
  logic [OUT_W-1:0]      div_coef;

  // clamp the bit size
  always_comb begin
    if (cfg.bit_size == '0) begin
      b = BW'(1);
    end else if (32'(cfg.bit_size) > 32'(MAX_BITS)) begin
      b = BW'(MAX_BITS);
    end else begin
      b = BW'(cfg.bit_size);
    end
    tb = {b, 1'b0};
  end

  // entropy from the accumulated sum
  always_comb begin
    term    = log_sum >> tb;
    two_b_q = LOG_SUM_W'(tb) << FRAC_W;
    h_wide  = (term >= two_b_q) ? '0 : two_b_q - term;
    h_next  = (h_wide > LOG_SUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : h_wide[OUT_W-1:0];
  end

  // proportion and total check
  always_comb begin
    if (32'(tb) <= 32'd31) begin
      prop_wide = 64'(first_bin_count) << (7'd31 - 7'(tb));
    end else begin
      prop_wide = 64'(first_bin_count) >> (7'(tb) - 7'd31);
    end
    prop_coef = (prop_wide > 64'(ONE_Q31)) ? ONE_Q31 : prop_wide[OUT_W-1:0];
    one_tb    = 64'd1 << tb;
    err_next  = (64'(total_count) != one_tb);
    div_coef  = (div_quo > 64'(ONE_Q31)) ? ONE_Q31 : div_quo[OUT_W-1:0];
    bound_arg = (COUNT_W'(1) << b) - COUNT_W'(1);
  end

  // shared units
  assign q_pop     = (st == B_IDLE) && q_valid;
  assign log_start = (q_pop && !q_item.zero) || (st == B_FIN && cfg.mode == MODE_BOUND);
  assign log_arg   = (st == B_IDLE) ? q_item.count : bound_arg;
  assign div_start = (st == B_FIN && cfg.mode == MODE_NORM) || (st == B_BLOG && log_done);
  assign div_num   = (st == B_FIN) ? {25'd0, h_next, 7'd0} : {1'b0, h, 31'd0};
  assign div_den   = (st == B_FIN) ? DIV_DEN_W'(tb)
                                   : (DIV_DEN_W'(b) << FRAC_W) + DIV_DEN_W'(log_res);

  hec_log2 u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .arg   (log_arg),
    .done  (log_done),
    .res   (log_res)
  );

  hec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // saturating adders
  assign tsum = {1'b0, total_count} + (TOTAL_W + 1)'(q_item.count);
  assign asum = 64'(log_sum) + 64'(prod);

  // result register
  assign out_load           = (st == B_OUT) && (!out_valid || result.ready);
  assign result.valid       = out_valid;

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.entropy     <= h;
      result.coefficient <= coef;
      result.count_error <= err;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= B_IDLE;
      log_sum         <= '0;
      total_count     <= '0;
      first_bin_count <= '0;
      first_item      <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        B_IDLE: begin
          if (q_valid) begin
            if (first_item) begin
              first_bin_count <= q_item.count;
              first_item      <= 1'b0;
            end
            total_count <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
            if (!q_item.zero) begin
              st <= B_LOG;
            end else if (q_item.last) begin
              st <= B_FIN;
            end
          end
        end
        B_LOG: begin
          if (log_done) begin
            st <= B_MUL0;
          end
        end
        B_MUL0: begin
          st <= B_MUL1;
        end
        B_MUL1: begin
          st <= B_SUM;
        end
        B_SUM: begin
          st <= B_ACC;
        end
        B_ACC: begin
          log_sum <= (asum[63:LOG_SUM_W] != '0) ? '1 : asum[LOG_SUM_W-1:0];
          st      <= is_last ? B_FIN : B_IDLE;
        end
        B_FIN: begin
          if (cfg.mode == MODE_NORM) begin
            st <= B_DIV;
          end else if (cfg.mode == MODE_BOUND) begin
            st <= B_BLOG;
          end else begin
            st <= B_OUT;
          end
        end
        B_BLOG: begin
          if (log_done) begin
            st <= B_DIV;
          end
        end
        B_DIV: begin
          if (div_done) begin
            st <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            log_sum         <= '0;
            total_count     <= '0;
            first_bin_count <= '0;
            first_item      <= 1'b1;
            st              <= B_IDLE;
          end
        end
        default: begin
          st <= B_IDLE;
        end
      endcase
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt     <= q_item.count;
      is_last <= q_item.last;
    end
    if (st == B_LOG && log_done) begin
      lg <= log_res;
    end
    if (st == B_MUL0) begin
      p_lo <= cnt * lg[HALF_W-1:0];
    end
    if (st == B_MUL1) begin
      p_hi <= cnt * lg[LOG_W-1:HALF_W];
    end
    if (st == B_SUM) begin
      prod <= (PROD_W'(p_hi) << HALF_W) + PROD_W'(p_lo);
    end
    if (st == B_FIN) begin
      h    <= h_next;
      coef <= (cfg.mode == MODE_PROP) ? prop_coef : '0;
      err  <= (cfg.mode == MODE_PROP) ? err_next : 1'b0;
    end
    if (st == B_DIV && div_done) begin
      coef <= div_coef;
    end
  end

endmodule

// ===== hw/rtl/histogram_entropy_coefficient.sv =====
// nonzero bin: the log2 unit shifts to the leading one and squares once per fraction bit,
// then two half multiplies, a sum and an accumulate; a zero bin skips log2 and multiply
// last bin: norm mode divides, bound mode runs the bound log2 then divides, prop mode outputs directly
// the back takes one bin at a time; a 4-word queue takes bins while the back works
// rst (synchronous) clears accumulators, empties the queue, sets bit_size 8 and mode 0
module histogram_entropy_coefficient #(
  parameter int MAX_BITS = hec_pkg::MAX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hec_pkg::CFG_DATA_W-1:0]   cfg_data,
  hec_hist_if.sink                         hist,
  hec_result_if.source                     result
);
  import hec_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_size <= BSIZE_RESET;
      cfg.mode     <= MODE_NORM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_SIZE: cfg.bit_size <= cfg_data[BSIZE_W-1:0];
        REG_MODE:     cfg.mode     <= cfg_data[MODE_W-1:0];
        default:      cfg.mode     <= cfg.mode;
      endcase
    end
  end

  hec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hist    (hist),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hec_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule
